// ----- rtl/core/priority_stack_sorted_insert_assert.svh -----
// ----------------------------------------------------------------------------
// priority stack assertion macros
// checks on the clock clk with the synchronous reset rst of the using module
// ----------------------------------------------------------------------------
`ifndef PRIORITY_STACK_SORTED_INSERT_ASSERT_SVH
`define PRIORITY_STACK_SORTED_INSERT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSQ_ASSERT_IMP(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("priority stack check failed");

// next-cycle implication
`define PSQ_ASSERT_NXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("priority stack check failed");

`else

`define PSQ_ASSERT_IMP(lbl, cond, expr)
`define PSQ_ASSERT_NXT(lbl, cond, expr)

`endif

`endif

// ----- rtl/core/psq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_pkg
// shared types of the priority stack: operation codes and control bundles
// ----------------------------------------------------------------------------
package psq_pkg;

  // operation carried by the mode field
  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } psq_mode_t;

  // slot memory access strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } psq_ram_ctl_t;

  // sequencer status toward the channel logic
  typedef struct packed {
    logic busy;
    logic done;
    logic err;
  } psq_status_t;

endpackage

// ----- rtl/core/psq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_ram
// slot memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module psq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  psq_pkg::psq_ram_ctl_t  ram_ctl,
  input  logic [AW-1:0]          wr_addr,
  input  logic [WIDTH-1:0]       wr_data,
  input  logic [AW-1:0]          rd_addr,
  output logic [WIDTH-1:0]       rd_data
);
  import psq_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ram_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (ram_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/psq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psq_ctrl
// sequencer that walks the slot memory one entry per read/compare pair,
// shifting entries down for a push and up for a pop
// ----------------------------------------------------------------------------
module psq_ctrl #(
  parameter int CAPACITY      = 16,
  parameter int VALUE_BITS    = 32,
  parameter int PRIORITY_BITS = 16,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = VALUE_BITS + PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     take,
  input  logic                     mode,
  input  logic [VALUE_BITS-1:0]    item_value,
  input  logic [PRIORITY_BITS-1:0] item_priority,
  output psq_pkg::psq_ram_ctl_t    ram_ctl,
  output logic [IW-1:0]            wr_addr,
  output logic [EW-1:0]            wr_data,
  output logic [IW-1:0]            rd_addr,
  input  logic [EW-1:0]            rd_data,
  output psq_pkg::psq_status_t     status,
  output logic [VALUE_BITS-1:0]    head_value,
  output logic [PRIORITY_BITS-1:0] head_priority,
  output logic [CW-1:0]            entry_count
);
  import psq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_INS,
    S_FIN
  } state_t;

  state_t                  state;
  psq_mode_t               op_mode;
  logic [VALUE_BITS-1:0]   op_value;
  logic [PRIORITY_BITS-1:0] op_pri;
  logic [IW-1:0]           idx;
  logic [CW-1:0]           count;
  logic                    err;
  logic [VALUE_BITS-1:0]   head_val;
  logic [PRIORITY_BITS-1:0] head_pri;

  logic [VALUE_BITS-1:0]    rd_val;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic                     shift;
  logic                     pop_last;

  // shared compare unit
  assign rd_val   = rd_data[EW-1:PRIORITY_BITS];
  assign rd_pri   = rd_data[PRIORITY_BITS-1:0];
  assign shift    = (rd_pri <= op_pri);
  assign pop_last = ({1'b0, CW'(idx)} + (CW+1)'(2)) >= {1'b0, count};

  // slot memory drive
  always_comb begin
    ram_ctl.rd_en = (state == S_RD);
    ram_ctl.wr_en = ((state == S_CMP) && ((op_mode == MODE_POP) || shift)) ||
                    (state == S_INS);
    rd_addr = (op_mode == MODE_POP) ? idx + IW'(1) : idx - IW'(1);
    wr_addr = idx;
    wr_data = (state == S_INS) ? {op_value, op_pri} : rd_data;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_mode  <= psq_mode_t'(mode);
            op_value <= item_value;
            op_pri   <= item_priority;
            err      <= 1'b0;
            if (psq_mode_t'(mode) == MODE_PUSH) begin
              if (count == CW'(CAPACITY)) begin
                err   <= 1'b1;
                state <= S_FIN;
              end else begin
                idx   <= count[IW-1:0];
                state <= (count == '0) ? S_INS : S_RD;
              end
            end else begin
              if (count == '0) begin
                err   <= 1'b1;
                state <= S_FIN;
              end else if (count == CW'(1)) begin
                count <= '0;
                state <= S_FIN;
              end else begin
                idx   <= '0;
                state <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (op_mode == MODE_PUSH) begin
            // move a lower or equal entry one slot toward the tail
            if (shift) begin
              idx   <= idx - IW'(1);
              state <= (idx == IW'(1)) ? S_INS : S_RD;
            end else begin
              state <= S_INS;
            end
          end else begin
            // move an entry one slot toward the head
            if (idx == '0) begin
              head_val <= rd_val;
              head_pri <= rd_pri;
            end
            idx <= idx + IW'(1);
            if (pop_last) begin
              count <= count - CW'(1);
              state <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_INS: begin
          if (idx == '0) begin
            head_val <= op_value;
            head_pri <= op_pri;
          end
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result view
  assign head_value    = (count == '0) ? '0 : head_val;
  assign head_priority = (count == '0) ? '0 : head_pri;
  assign entry_count   = count;
  assign status.busy   = (state != S_IDLE);
  assign status.done   = (state == S_FIN);
  assign status.err    = err;

endmodule

// ----- rtl/core/priority_stack_sorted_insert.sv -----
`timescale 1ns / 1ps
// push: each stored entry of lower or equal priority is read and moved one slot
// toward the tail, then the item is written into the freed slot
// pop: each remaining entry is read and moved one slot toward the head
// refused push/pop: error set; one item at a time, set by the slot memory walk
// one result is held in an output register while the next item is worked on
// reset clears the entry count and control; the slot memory is not cleared
// ----------------------------------------------------------------------------
// priority_stack_sorted_insert
// bounded priority stack kept in a sorted slot memory, highest priority first
// ----------------------------------------------------------------------------
`include "priority_stack_sorted_insert_assert.svh"

module priority_stack_sorted_insert #(
  parameter int CAPACITY      = 16,
  parameter int VALUE_BITS    = 32,
  parameter int PRIORITY_BITS = 16,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = VALUE_BITS + PRIORITY_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     mode,
  input  logic [VALUE_BITS-1:0]    item_value,
  input  logic [PRIORITY_BITS-1:0] item_priority,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [VALUE_BITS-1:0]    head_value,
  output logic [PRIORITY_BITS-1:0] head_priority,
  output logic [CW-1:0]            entry_count,
  output logic                     is_empty,
  output logic                     op_error
);
  import psq_pkg::*;

  psq_ram_ctl_t             ram_ctl;
  psq_status_t              status;
  logic [IW-1:0]            wr_addr;
  logic [IW-1:0]            rd_addr;
  logic [EW-1:0]            wr_data;
  logic [EW-1:0]            rd_data;
  logic [VALUE_BITS-1:0]    seq_value;
  logic [PRIORITY_BITS-1:0] seq_priority;
  logic [CW-1:0]            seq_count;
  logic                     start;
  logic                     take;

  // input handshake
  assign item_stall = status.busy;
  assign start      = item_valid && !item_stall;

  // output register is free when empty or being drained
  assign take = status.done && (!result_valid || !result_stall);

  psq_ctrl #(
    .CAPACITY      (CAPACITY),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .take          (take),
    .mode          (mode),
    .item_value    (item_value),
    .item_priority (item_priority),
    .ram_ctl       (ram_ctl),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .status        (status),
    .head_value    (seq_value),
    .head_priority (seq_priority),
    .entry_count   (seq_count)
  );

  psq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .ram_ctl (ram_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      head_value    <= seq_value;
      head_priority <= seq_priority;
      entry_count   <= seq_count;
      is_empty      <= (seq_count == '0);
      op_error      <= status.err;
    end
  end

  // checks
  `PSQ_ASSERT_NXT(a_stall_after_accept, item_valid && !item_stall, item_stall)
  `PSQ_ASSERT_IMP(a_count_bound, result_valid, entry_count <= CW'(CAPACITY))
  `PSQ_ASSERT_IMP(a_empty_flag, result_valid, is_empty == (entry_count == '0))
  `PSQ_ASSERT_IMP(a_empty_head, result_valid && is_empty, head_value == '0 && head_priority == '0)

endmodule
